// ===== rtl/chp_pkg.sv =====
// shared constants, codes and request types of the cookie header parser
`timescale 1ns / 1ps

package chp_pkg;

  // default token buffer depth and the position width that covers the widest legal depth
  localparam int CHP_TOKEN_DEPTH = 64;
  localparam int POS_W = 7;

  // result queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = 2;
  localparam int OQ_CW = 3;

  // characters the parser reacts to
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_ERROR = 2'd2
  } chp_kind_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_NAME,
    BK_VALUE,
    BK_ERR
  } chp_bk_state_t;

  // token write request from the front end into the token memory
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [POS_W-1:0] idx;
    logic [7:0]       data;
  } chp_wr_t;

  // classified token: error flag, bank, trimmed name span and value span
  typedef struct packed {
    logic             err;
    logic             bank;
    logic [POS_W-1:0] s;
    logic [POS_W-1:0] ne;
    logic [POS_W-1:0] vs;
    logic [POS_W-1:0] ve;
  } chp_desc_t;

  // bank handed back to the front end once its token is emitted
  typedef struct packed {
    logic valid;
    logic bank;
  } chp_rel_t;

endpackage

// ===== rtl/cookie_header_parser.sv =====
// top level of the cookie header parser
// input takes one byte per cycle while the token bank being filled is free; two banks alternate
// a cookie's first result goes through the token queue, sequencer, read stage and result queue
// results enter the result queue at one per cycle while it has room, with an idle state per cookie
// an error result for an overlong token passes the idle and error states of the back end
// reset clears queues, bank ownership and the tracker; token memory is not cleared
`timescale 1ns / 1ps

module cookie_header_parser #(
  parameter int TOKEN_DEPTH = chp_pkg::CHP_TOKEN_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] header_byte,
  input  logic       final_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       cookie_end,
  output logic       empty,
  input  logic       pop
);

  chp_pkg::chp_wr_t   wr;
  chp_pkg::chp_desc_t desc;
  chp_pkg::chp_desc_t head;
  chp_pkg::chp_rel_t  rel;
  logic               desc_push;
  logic               dq_valid;
  logic               dq_pop;

  // byte intake and token classification
  chp_front #(
    .TOKEN_DEPTH(TOKEN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .header_byte(header_byte),
    .final_byte (final_byte),
    .push       (push),
    .full       (full),
    .wr         (wr),
    .desc_push  (desc_push),
    .desc       (desc),
    .rel        (rel)
  );

  // token queue between the halves
  chp_desc_queue u_dq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_push),
    .wr_desc (desc),
    .rd_en   (dq_pop),
    .rd_valid(dq_valid),
    .rd_desc (head)
  );

  // emit side
  chp_back #(
    .TOKEN_DEPTH(TOKEN_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .dq_valid  (dq_valid),
    .head      (head),
    .dq_pop    (dq_pop),
    .rel       (rel),
    .out_byte  (out_byte),
    .byte_kind (byte_kind),
    .cookie_end(cookie_end),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== rtl/chp_front.sv =====
// front end: takes header bytes, fills the token banks and classifies each token
`timescale 1ns / 1ps

module chp_front #(
  parameter int TOKEN_DEPTH = chp_pkg::CHP_TOKEN_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          header_byte,
  input  logic                final_byte,
  input  logic                push,
  output logic                full,
  output chp_pkg::chp_wr_t    wr,
  output logic                desc_push,
  output chp_pkg::chp_desc_t  desc,
  input  chp_pkg::chp_rel_t   rel
);

  localparam int PW = chp_pkg::POS_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(TOKEN_DEPTH);

  // control state
  logic [PW-1:0] fill, fill_next;
  logic          ovf, ovf_next;
  logic          have_s, have_s_next;
  logic          eq_found, eq_found_next;
  logic          expect_first, expect_first_next;
  logic          bank_cur, bank_cur_next;
  logic [1:0]    busy, busy_next;

  // token shape tracked on the fly
  logic [PW-1:0] s, s_next;
  logic [PW-1:0] e, e_next;
  logic [PW-1:0] eq, eq_next;
  logic [PW-1:0] ne, ne_next;
  logic          name_ok, name_ok_next;
  logic          first_q, first_q_next;
  logic          last_q, last_q_next;

  logic          accept;
  logic          is_semi;
  logic          room;
  logic          store;
  logic          nb;
  logic          is_quote;
  logic          token_end;
  logic          strip;
  logic          drop;
  logic [PW:0]   eq_plus3;

  assign full     = busy[bank_cur];
  assign accept   = push && !full;
  assign is_semi  = (header_byte == chp_pkg::CHR_SEMI);
  assign room     = (fill < DEPTH_P);
  assign store    = accept && !is_semi && room;
  assign nb       = (header_byte != chp_pkg::CHR_SPACE) && (header_byte != chp_pkg::CHR_TAB);
  assign is_quote = (header_byte == chp_pkg::CHR_QUOTE);
  assign token_end = accept && (is_semi || final_byte);

  // token write into the current bank
  always_comb begin
    wr.en   = store;
    wr.bank = bank_cur;
    wr.idx  = fill;
    wr.data = header_byte;
  end

  // tracking update, classification at token end, bank handover
  always_comb begin
    fill_next         = fill;
    ovf_next          = ovf;
    have_s_next       = have_s;
    eq_found_next     = eq_found;
    expect_first_next = expect_first;
    s_next            = s;
    e_next            = e;
    eq_next           = eq;
    ne_next           = ne;
    name_ok_next      = name_ok;
    first_q_next      = first_q;
    last_q_next       = last_q;
    bank_cur_next     = bank_cur;
    busy_next         = busy;

    // shape of the token including this byte
    if (store) begin
      fill_next = fill + PW'(1);
      if (nb && !have_s) begin
        have_s_next = 1'b1;
        s_next      = fill;
      end
      if (nb) begin
        e_next      = fill + PW'(1);
        last_q_next = is_quote;
      end
      if (expect_first) begin
        first_q_next      = is_quote;
        expect_first_next = 1'b0;
      end
      if (!eq_found && header_byte == chp_pkg::CHR_EQ) begin
        eq_found_next     = 1'b1;
        eq_next           = fill;
        ne_next           = e;
        name_ok_next      = have_s;
        expect_first_next = 1'b1;
      end
    end
    if (accept && !is_semi && !room) begin
      ovf_next = 1'b1;
    end

    // classification from the updated shape
    eq_plus3 = {1'b0, eq_next} + (PW+1)'(3);
    strip    = first_q_next && last_q_next && ({1'b0, e_next} >= eq_plus3);
    drop     = !have_s_next || !eq_found_next || !name_ok_next;
    desc.err  = ovf_next;
    desc.bank = bank_cur;
    desc.s    = s_next;
    desc.ne   = ne_next;
    desc.vs   = strip ? (eq_next + PW'(2)) : (eq_next + PW'(1));
    desc.ve   = strip ? (e_next - PW'(1)) : e_next;
    desc_push = token_end && (ovf_next || !drop);

    // token end clears the tracker
    if (token_end) begin
      fill_next         = '0;
      ovf_next          = 1'b0;
      have_s_next       = 1'b0;
      eq_found_next     = 1'b0;
      expect_first_next = 1'b0;
    end

    // bank ownership
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (desc_push) begin
      busy_next[bank_cur] = 1'b1;
      bank_cur_next       = ~bank_cur;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      ovf          <= 1'b0;
      have_s       <= 1'b0;
      eq_found     <= 1'b0;
      expect_first <= 1'b0;
      bank_cur     <= 1'b0;
      busy         <= '0;
    end else begin
      fill         <= fill_next;
      ovf          <= ovf_next;
      have_s       <= have_s_next;
      eq_found     <= eq_found_next;
      expect_first <= expect_first_next;
      bank_cur     <= bank_cur_next;
      busy         <= busy_next;
    end
  end

  // shape registers
  always_ff @(posedge clk) begin
    s       <= s_next;
    e       <= e_next;
    eq      <= eq_next;
    ne      <= ne_next;
    name_ok <= name_ok_next;
    first_q <= first_q_next;
    last_q  <= last_q_next;
  end

endmodule

// ===== rtl/chp_desc_queue.sv =====
// two-entry queue of classified tokens between the front and back ends
`timescale 1ns / 1ps

module chp_desc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  chp_pkg::chp_desc_t  wr_desc,
  input  logic                rd_en,
  output logic                rd_valid,
  output chp_pkg::chp_desc_t  rd_desc
);

  chp_pkg::chp_desc_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;

  assign rd_valid = (cnt != 2'd0);
  assign rd_desc  = entry[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry[wptr] <= wr_desc;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr_en) begin
        wptr <= ~wptr;
      end
      if (rd_en) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end

endmodule

// ===== rtl/chp_back.sv =====
// back end: token memory, emit sequencer and result queue
`timescale 1ns / 1ps

module chp_back #(
  parameter int TOKEN_DEPTH = chp_pkg::CHP_TOKEN_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  chp_pkg::chp_wr_t    wr,
  input  logic                dq_valid,
  input  chp_pkg::chp_desc_t  head,
  output logic                dq_pop,
  output chp_pkg::chp_rel_t   rel,
  output logic [7:0]          out_byte,
  output logic [1:0]          byte_kind,
  output logic                cookie_end,
  output logic                empty,
  input  logic                pop
);

  localparam int PW = chp_pkg::POS_W;
  localparam int IW = (TOKEN_DEPTH > 1) ? $clog2(TOKEN_DEPTH) : 1;
  localparam int AW = IW + 1;
  localparam int CW = chp_pkg::OQ_CW;
  localparam int QW = chp_pkg::OQ_AW;

  // token memory, two banks
  logic [7:0] mem [2**AW];
  logic [7:0] rd_data;
  logic [AW-1:0] raddr;

  // sequencer
  chp_pkg::chp_bk_state_t state, state_next;
  logic [PW-1:0] ptr, ptr_next;
  logic          credit;
  logic          issue;
  logic          iss_err;
  logic          iss_end;
  chp_pkg::chp_kind_t iss_kind;
  logic [PW-1:0] ptr_inc;

  // read stage
  logic          s1_valid;
  logic          s1_err;
  logic          s1_end;
  chp_pkg::chp_kind_t s1_kind;

  // result queue
  logic [7:0]         oq_byte [chp_pkg::OQ_DEPTH];
  chp_pkg::chp_kind_t oq_kind [chp_pkg::OQ_DEPTH];
  logic               oq_end  [chp_pkg::OQ_DEPTH];
  logic [QW-1:0]      oq_wptr;
  logic [QW-1:0]      oq_rptr;
  logic [CW-1:0]      oq_cnt;
  logic               oq_pop;

  assign raddr = {head.bank, ptr[IW-1:0]};

  // token memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[IW-1:0]}] <= wr.data;
    end
    rd_data <= mem[raddr];
  end

  // room for one more request counting the one in the read stage
  assign credit  = ((oq_cnt + CW'(s1_valid)) < CW'(chp_pkg::OQ_DEPTH));
  assign ptr_inc = ptr + PW'(1);
  assign rel.valid = dq_pop;
  assign rel.bank  = head.bank;

  // emit sequencer
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    issue      = 1'b0;
    iss_err    = 1'b0;
    iss_end    = 1'b0;
    iss_kind   = chp_pkg::KIND_NAME;
    dq_pop     = 1'b0;
    case (state)
      chp_pkg::BK_IDLE: begin
        if (dq_valid) begin
          if (head.err) begin
            state_next = chp_pkg::BK_ERR;
          end else begin
            ptr_next   = head.s;
            state_next = chp_pkg::BK_NAME;
          end
        end
      end
      chp_pkg::BK_ERR: begin
        if (credit) begin
          issue      = 1'b1;
          iss_err    = 1'b1;
          iss_end    = 1'b1;
          iss_kind   = chp_pkg::KIND_ERROR;
          dq_pop     = 1'b1;
          state_next = chp_pkg::BK_IDLE;
        end
      end
      chp_pkg::BK_NAME: begin
        if (credit) begin
          issue    = 1'b1;
          iss_kind = chp_pkg::KIND_NAME;
          iss_end  = (ptr_inc == head.ne) && (head.vs == head.ve);
          if (ptr_inc == head.ne) begin
            if (head.vs == head.ve) begin
              dq_pop     = 1'b1;
              state_next = chp_pkg::BK_IDLE;
            end else begin
              ptr_next   = head.vs;
              state_next = chp_pkg::BK_VALUE;
            end
          end else begin
            ptr_next = ptr_inc;
          end
        end
      end
      chp_pkg::BK_VALUE: begin
        if (credit) begin
          issue    = 1'b1;
          iss_kind = chp_pkg::KIND_VALUE;
          iss_end  = (ptr_inc == head.ve);
          if (ptr_inc == head.ve) begin
            dq_pop     = 1'b1;
            state_next = chp_pkg::BK_IDLE;
          end else begin
            ptr_next = ptr_inc;
          end
        end
      end
      default: begin
        state_next = chp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= chp_pkg::BK_IDLE;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= issue;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    s1_err  <= iss_err;
    s1_end  <= iss_end;
    s1_kind <= iss_kind;
  end

  // result queue
  assign empty      = (oq_cnt == '0);
  assign oq_pop     = pop && !empty;
  assign out_byte   = oq_byte[oq_rptr];
  assign byte_kind  = oq_kind[oq_rptr];
  assign cookie_end = oq_end[oq_rptr];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq_byte[oq_wptr] <= s1_err ? 8'd0 : rd_data;
      oq_kind[oq_wptr] <= s1_kind;
      oq_end[oq_wptr]  <= s1_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr <= '0;
      oq_rptr <= '0;
      oq_cnt  <= '0;
    end else begin
      if (s1_valid) begin
        oq_wptr <= oq_wptr + QW'(1);
      end
      if (oq_pop) begin
        oq_rptr <= oq_rptr + QW'(1);
      end
      oq_cnt <= oq_cnt + CW'(s1_valid) - CW'(oq_pop);
    end
  end

endmodule

// ===== rtl/chp_checker.sv =====
// port level checks of the cookie header parser and their binding
`timescale 1ns / 1ps

module chp_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic [7:0] out_byte,
  input logic [1:0] byte_kind,
  input logic       cookie_end,
  input logic       empty,
  input logic       pop
);

  // an error result is a lone zero byte that closes its cookie
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && byte_kind == chp_pkg::KIND_ERROR) |-> (out_byte == 8'd0 && cookie_end))
    else $error("error result malformed");

  // a value byte that does not end its cookie is followed by another value byte
  a_value_run: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && byte_kind == chp_pkg::KIND_VALUE && !cookie_end)
      |=> (empty || byte_kind == chp_pkg::KIND_VALUE))
    else $error("value run broken");

  // a name byte that does not end its cookie is never followed by an error result
  a_name_run: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && byte_kind == chp_pkg::KIND_NAME && !cookie_end)
      |=> (empty || byte_kind != chp_pkg::KIND_ERROR))
    else $error("cookie cut by error result");

  // reset leaves no results and room for input
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("state after reset wrong");

  // a waiting result holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(byte_kind)
      && $stable(cookie_end)))
    else $error("waiting result changed");

endmodule

bind cookie_header_parser chp_checker u_chp_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .out_byte  (out_byte),
  .byte_kind (byte_kind),
  .cookie_end(cookie_end),
  .empty     (empty),
  .pop       (pop)
);
